>>> design/rv64ex_pkg.sv
// ============================================================================
// rv64ex_pkg - shared types and constants of the rv64i execute unit
// operation codes, register file port structs and the result record
// ============================================================================
`default_nettype none

package rv64ex_pkg;

    localparam int XLEN        = 64;
    localparam int REG_IDX_W   = 5;
    localparam int REG_COUNT   = 32;
    localparam int IMM_W       = 32;
    localparam int IN_TDATA_W  = 248;
    localparam int OUT_TDATA_W = 264;

    // dense operation numbering
    typedef enum logic [5:0] {
        OP_ADD   = 6'd0,  OP_SUB   = 6'd1,  OP_SLT   = 6'd2,  OP_SLTU  = 6'd3,
        OP_XOR   = 6'd4,  OP_SLL   = 6'd5,  OP_SRL   = 6'd6,  OP_SRA   = 6'd7,
        OP_OR    = 6'd8,  OP_AND   = 6'd9,  OP_ADDW  = 6'd10, OP_SLLW  = 6'd11,
        OP_SRLW  = 6'd12, OP_SUBW  = 6'd13, OP_SRAW  = 6'd14, OP_JALR  = 6'd15,
        OP_LD    = 6'd16, OP_LB    = 6'd17, OP_LBU   = 6'd18, OP_LH    = 6'd19,
        OP_LHU   = 6'd20, OP_LW    = 6'd21, OP_LWU   = 6'd22, OP_ADDI  = 6'd23,
        OP_SLTI  = 6'd24, OP_SLTIU = 6'd25, OP_ANDI  = 6'd26, OP_ORI   = 6'd27,
        OP_XORI  = 6'd28, OP_SLLI  = 6'd29, OP_SRLI  = 6'd30, OP_SRAI  = 6'd31,
        OP_ADDIW = 6'd32, OP_SLLIW = 6'd33, OP_SRLIW = 6'd34, OP_SRAIW = 6'd35,
        OP_SB    = 6'd36, OP_SH    = 6'd37, OP_SW    = 6'd38, OP_SD    = 6'd39,
        OP_BEQ   = 6'd40, OP_BNE   = 6'd41, OP_BLT   = 6'd42, OP_BLTU  = 6'd43,
        OP_BGE   = 6'd44, OP_BGEU  = 6'd45, OP_LUI   = 6'd46, OP_AUIPC = 6'd47,
        OP_JAL   = 6'd48
    } t_op;

    typedef enum logic [1:0] {
        MEM_NONE  = 2'd0,
        MEM_LOAD  = 2'd1,
        MEM_STORE = 2'd2
    } t_mem;

    typedef enum logic [1:0] {
        SZ_BYTE   = 2'd0,
        SZ_HALF   = 2'd1,
        SZ_WORD   = 2'd2,
        SZ_DOUBLE = 2'd3
    } t_size;

    // request as held in the execute register
    typedef struct packed {
        t_op                    op;
        logic [REG_IDX_W-1:0]   dest;
        logic [IMM_W-1:0]       imm;
        logic [XLEN-1:0]        cur_pc;
        logic [XLEN-1:0]        seq_pc;
        logic [XLEN-1:0]        load_data;
    } t_req;

    typedef struct packed {
        logic                   en;
        logic [REG_IDX_W-1:0]   addr1;
        logic [REG_IDX_W-1:0]   addr2;
    } t_rf_rd;

    typedef struct packed {
        logic                   en;
        logic [REG_IDX_W-1:0]   addr;
        logic [XLEN-1:0]        data;
    } t_rf_wr;

    typedef struct packed {
        logic                   redirect;
        logic [XLEN-1:0]        target_pc;
        logic                   reg_written;
        logic [XLEN-1:0]        write_value;
        t_mem                   mem_access;
        t_size                  access_size;
        logic [XLEN-1:0]        access_addr;
        logic [XLEN-1:0]        store_value;
    } t_result;

    function automatic logic [XLEN-1:0] sext32(input logic [31:0] v);
        return {{(XLEN-32){v[31]}}, v};
    endfunction

endpackage

`default_nettype wire

>>> design/rv64ex_regfile.sv
// ============================================================================
// rv64ex_regfile - 32 x 64 register file
// two registered read ports, one write port, per-entry valid bits for the
// all-zero reset, and a bypass of the write that lands on the read edge
// ============================================================================
`default_nettype none

module rv64ex_regfile (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rv64ex_pkg::t_rf_rd              i_rd,
    input  rv64ex_pkg::t_rf_wr              i_wr,
    output logic [rv64ex_pkg::XLEN-1:0]     o_rs1,
    output logic [rv64ex_pkg::XLEN-1:0]     o_rs2
);
    import rv64ex_pkg::*;

    logic [XLEN-1:0]        r_mem [REG_COUNT];
    logic [REG_COUNT-1:0]   r_valid;

    logic [XLEN-1:0]        r_rd1_data, r_rd2_data;
    logic [REG_IDX_W-1:0]   r_rd1_idx,  r_rd2_idx;
    logic                   r_rd1_vld,  r_rd2_vld;

    // last write, covers a read taken on the same edge as that write
    logic                   r_byp_vld;
    logic [REG_IDX_W-1:0]   r_byp_idx;
    logic [XLEN-1:0]        r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd1_data <= r_mem[i_rd.addr1];
            r_rd2_data <= r_mem[i_rd.addr2];
            r_rd1_vld  <= r_valid[i_rd.addr1];
            r_rd2_vld  <= r_valid[i_rd.addr2];
            r_rd1_idx  <= i_rd.addr1;
            r_rd2_idx  <= i_rd.addr2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_byp_vld <= 1'b0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
            r_byp_vld          <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_byp_idx  <= i_wr.addr;
            r_byp_data <= i_wr.data;
        end
    end

    always_comb begin
        priority if (r_byp_vld && r_byp_idx == r_rd1_idx) begin
            o_rs1 = r_byp_data;
        end else if (r_rd1_vld) begin
            o_rs1 = r_rd1_data;
        end else begin
            o_rs1 = '0;
        end
    end

    always_comb begin
        priority if (r_byp_vld && r_byp_idx == r_rd2_idx) begin
            o_rs2 = r_byp_data;
        end else if (r_rd2_vld) begin
            o_rs2 = r_rd2_data;
        end else begin
            o_rs2 = '0;
        end
    end

endmodule

`default_nettype wire

>>> design/rv64ex_alu.sv
// ============================================================================
// rv64ex_alu - execute logic
// alu, shifter, compares, load extension, address and branch target
// ============================================================================
`default_nettype none

module rv64ex_alu (
    input  rv64ex_pkg::t_req                i_req,
    input  logic [rv64ex_pkg::XLEN-1:0]     i_rs1,
    input  logic [rv64ex_pkg::XLEN-1:0]     i_rs2,
    output rv64ex_pkg::t_result             o_res
);
    import rv64ex_pkg::*;

    logic [XLEN-1:0]    a, b, imm64, addr, pc_tgt, val, tgt, sval;
    logic [5:0]         sh6b, sh6i;
    logic [4:0]         sh5b, sh5i;
    logic [31:0]        a32;
    logic               lt_ab, ltu_ab, lt_ai, ltu_ai;
    logic               wr, redir, taken, do_wr;
    t_mem               mem;
    t_size              size;

    assign a      = i_rs1;
    assign b      = i_rs2;
    assign a32    = i_rs1[31:0];
    assign imm64  = sext32(i_req.imm);
    assign addr   = a + imm64;
    assign pc_tgt = i_req.cur_pc + imm64;
    assign sh6b   = b[5:0];
    assign sh5b   = b[4:0];
    assign sh6i   = i_req.imm[5:0];
    assign sh5i   = i_req.imm[4:0];
    assign lt_ab  = $signed(a) < $signed(b);
    assign ltu_ab = a < b;
    assign lt_ai  = $signed(a) < $signed(imm64);
    assign ltu_ai = a < imm64;

    always_comb begin
        wr    = 1'b0;
        redir = 1'b0;
        taken = 1'b0;
        val   = '0;
        tgt   = '0;
        sval  = '0;
        mem   = MEM_NONE;
        size  = SZ_BYTE;
        unique case (i_req.op)
            OP_ADD:   begin wr = 1'b1; val = a + b; end
            OP_SUB:   begin wr = 1'b1; val = a - b; end
            OP_SLT:   begin wr = 1'b1; val = {{(XLEN-1){1'b0}}, lt_ab}; end
            OP_SLTU:  begin wr = 1'b1; val = {{(XLEN-1){1'b0}}, ltu_ab}; end
            OP_XOR:   begin wr = 1'b1; val = a ^ b; end
            OP_SLL:   begin wr = 1'b1; val = a << sh6b; end
            OP_SRL:   begin wr = 1'b1; val = a >> sh6b; end
            OP_SRA:   begin wr = 1'b1; val = $signed(a) >>> sh6b; end
            OP_OR:    begin wr = 1'b1; val = a | b; end
            OP_AND:   begin wr = 1'b1; val = a & b; end
            OP_ADDW:  begin wr = 1'b1; val = sext32(a32 + b[31:0]); end
            OP_SLLW:  begin wr = 1'b1; val = sext32(a32 << sh5b); end
            OP_SRLW:  begin wr = 1'b1; val = sext32(a32 >> sh5b); end
            OP_SUBW:  begin wr = 1'b1; val = sext32(a32 - b[31:0]); end
            OP_SRAW:  begin wr = 1'b1; val = sext32($signed(a32) >>> sh5b); end
            OP_JALR:  begin
                wr    = 1'b1;
                val   = i_req.seq_pc;
                redir = 1'b1;
                tgt   = {addr[XLEN-1:1], 1'b0};
            end
            OP_LD:    begin wr = 1'b1; mem = MEM_LOAD; size = SZ_DOUBLE;
                            val = i_req.load_data; end
            OP_LB:    begin wr = 1'b1; mem = MEM_LOAD; size = SZ_BYTE;
                            val = {{(XLEN-8){i_req.load_data[7]}}, i_req.load_data[7:0]}; end
            OP_LBU:   begin wr = 1'b1; mem = MEM_LOAD; size = SZ_BYTE;
                            val = {{(XLEN-8){1'b0}}, i_req.load_data[7:0]}; end
            OP_LH:    begin wr = 1'b1; mem = MEM_LOAD; size = SZ_HALF;
                            val = {{(XLEN-16){i_req.load_data[15]}}, i_req.load_data[15:0]}; end
            OP_LHU:   begin wr = 1'b1; mem = MEM_LOAD; size = SZ_HALF;
                            val = {{(XLEN-16){1'b0}}, i_req.load_data[15:0]}; end
            OP_LW:    begin wr = 1'b1; mem = MEM_LOAD; size = SZ_WORD;
                            val = sext32(i_req.load_data[31:0]); end
            OP_LWU:   begin wr = 1'b1; mem = MEM_LOAD; size = SZ_WORD;
                            val = {{(XLEN-32){1'b0}}, i_req.load_data[31:0]}; end
            OP_ADDI:  begin wr = 1'b1; val = addr; end
            OP_SLTI:  begin wr = 1'b1; val = {{(XLEN-1){1'b0}}, lt_ai}; end
            OP_SLTIU: begin wr = 1'b1; val = {{(XLEN-1){1'b0}}, ltu_ai}; end
            OP_ANDI:  begin wr = 1'b1; val = a & imm64; end
            OP_ORI:   begin wr = 1'b1; val = a | imm64; end
            OP_XORI:  begin wr = 1'b1; val = a ^ imm64; end
            OP_SLLI:  begin wr = 1'b1; val = a << sh6i; end
            OP_SRLI:  begin wr = 1'b1; val = a >> sh6i; end
            OP_SRAI:  begin wr = 1'b1; val = $signed(a) >>> sh6i; end
            OP_ADDIW: begin wr = 1'b1; val = sext32(addr[31:0]); end
            OP_SLLIW: begin wr = 1'b1; val = sext32(a32 << sh5i); end
            OP_SRLIW: begin wr = 1'b1; val = sext32(a32 >> sh5i); end
            OP_SRAIW: begin wr = 1'b1; val = sext32($signed(a32) >>> sh5i); end
            OP_SB:    begin mem = MEM_STORE; size = SZ_BYTE;
                            sval = {{(XLEN-8){1'b0}}, b[7:0]}; end
            OP_SH:    begin mem = MEM_STORE; size = SZ_HALF;
                            sval = {{(XLEN-16){1'b0}}, b[15:0]}; end
            OP_SW:    begin mem = MEM_STORE; size = SZ_WORD;
                            sval = {{(XLEN-32){1'b0}}, b[31:0]}; end
            OP_SD:    begin mem = MEM_STORE; size = SZ_DOUBLE; sval = b; end
            OP_BEQ:   taken = (a == b);
            OP_BNE:   taken = (a != b);
            OP_BLT:   taken = lt_ab;
            OP_BLTU:  taken = ltu_ab;
            OP_BGE:   taken = !lt_ab;
            OP_BGEU:  taken = !ltu_ab;
            OP_LUI:   begin wr = 1'b1; val = imm64; end
            OP_AUIPC: begin wr = 1'b1; val = pc_tgt; end
            OP_JAL:   begin
                wr    = 1'b1;
                val   = i_req.seq_pc;
                redir = 1'b1;
                tgt   = pc_tgt;
            end
            default:  ;
        endcase
        if (taken) begin
            redir = 1'b1;
            tgt   = pc_tgt;
        end
    end

    // x0 destination drops the write
    assign do_wr = wr && (i_req.dest != '0);

    always_comb begin
        o_res.redirect    = redir;
        o_res.target_pc   = redir ? tgt : '0;
        o_res.reg_written = do_wr;
        o_res.write_value = do_wr ? val : '0;
        o_res.mem_access  = mem;
        o_res.access_size = (mem != MEM_NONE) ? size : SZ_BYTE;
        o_res.access_addr = (mem != MEM_NONE) ? addr : '0;
        o_res.store_value = sval;
    end

endmodule

`default_nettype wire

>>> design/rv64i_execute_unit.sv
// ============================================================================
// rv64i_execute_unit - rv64i execute stage
// executes one decoded instruction per request against a 32 x 64 register
// file and reports writeback, memory access and control redirect
// ============================================================================
//
//  channel   dir  handshake                     payload
//  --------  ---  ----------------------------  ----------------------------
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  decoded instruction, 248 b
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  execute result, 264 b
//
//  one request per cycle sustained while results drain; a request's result
//  is registered after its operand read edge, then the execute/writeback edge
//  the writeback of one request and the operand read of the next share an
//  edge; the register file bypass register closes that gap
//  reset clears the register file at once through per-entry valid bits
//  a stalled result holds in the output register while one more request
//  waits in the execute register; input stalls only when both are full
//
`default_nettype none

module rv64i_execute_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // [5:0] req_type, [10:6] src1_index, [15:11] src2_index,
    // [20:16] dest_index, [52:21] immediate, [116:53] cur_pc,
    // [180:117] seq_pc, [244:181] load_data, [247:245] zero
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  logic [rv64ex_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,
    // [0] redirect, [64:1] target_pc, [65] reg_written,
    // [129:66] write_value, [131:130] mem_access, [133:132] access_size,
    // [197:134] access_addr, [261:198] store_value, [263:262] zero
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    output logic [rv64ex_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);
    import rv64ex_pkg::*;

    // execute register
    logic       r_s1_valid, n_s1_valid;
    t_req       r_req;

    // result register
    logic       r_out_valid, n_out_valid;
    t_result    r_res;

    logic       s_accept;
    logic       advance;
    logic [XLEN-1:0] rs1, rs2;
    t_result    res;
    t_rf_rd     rf_rd;
    t_rf_wr     rf_wr;

    // execute register moves on when the result register is free or drains
    assign advance         = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // operand reads are taken on the accept edge
    always_comb begin
        rf_rd.en    = s_accept;
        rf_rd.addr1 = i_s_axis_tdata[10:6];
        rf_rd.addr2 = i_s_axis_tdata[15:11];
    end

    // writeback commits when the result enters the output register
    always_comb begin
        rf_wr.en   = advance && res.reg_written;
        rf_wr.addr = r_req.dest;
        rf_wr.data = res.write_value;
    end

    rv64ex_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rf_rd),
        .i_wr    (rf_wr),
        .o_rs1   (rs1),
        .o_rs2   (rs2)
    );

    rv64ex_alu u_alu (
        .i_req (r_req),
        .i_rs1 (rs1),
        .i_rs2 (rs2),
        .o_res (res)
    );

    always_comb begin
        priority if (s_accept) begin
            n_s1_valid = 1'b1;
        end else if (advance) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_comb begin
        priority if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // request payload capture
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req.op        <= t_op'(i_s_axis_tdata[5:0]);
            r_req.dest      <= i_s_axis_tdata[20:16];
            r_req.imm       <= i_s_axis_tdata[52:21];
            r_req.cur_pc    <= i_s_axis_tdata[116:53];
            r_req.seq_pc    <= i_s_axis_tdata[180:117];
            r_req.load_data <= i_s_axis_tdata[244:181];
        end
    end

    // result payload capture
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

    always_comb begin
        o_m_axis_tdata            = '0;
        o_m_axis_tdata[0]         = r_res.redirect;
        o_m_axis_tdata[64:1]      = r_res.target_pc;
        o_m_axis_tdata[65]        = r_res.reg_written;
        o_m_axis_tdata[129:66]    = r_res.write_value;
        o_m_axis_tdata[131:130]   = r_res.mem_access;
        o_m_axis_tdata[133:132]   = r_res.access_size;
        o_m_axis_tdata[197:134]   = r_res.access_addr;
        o_m_axis_tdata[261:198]   = r_res.store_value;
    end

endmodule

`default_nettype wire

>>> design/rv64ex_checker.sv
// ============================================================================
// rv64ex_checker - port-level checks of the rv64i execute unit
// result field consistency and output handshake behavior
// ============================================================================
`default_nettype none

module rv64ex_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    input  logic [rv64ex_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata
);
    import rv64ex_pkg::*;

    // no result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // no redirect means zero target
    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[64:1] == '0))
        else $error("target set without redirect");

    // no write means zero write value
    a_wvalue_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[65]) |-> (o_m_axis_tdata[129:66] == '0))
        else $error("write value set without register write");

    // no memory access means zero size and address
    a_mem_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[131:130] == MEM_NONE)
            |-> (o_m_axis_tdata[133:132] == '0 && o_m_axis_tdata[197:134] == '0))
        else $error("access fields set without memory access");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
            |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind rv64i_execute_unit rv64ex_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

>>> verif/tb.sv
// ============================================================================
// tb - testbench of the rv64i execute unit
// drives decoded instructions into the request stream and checks every result
// against a typed row result or an in-bench execute model with its own registers
// ============================================================================

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rv64ex_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 10;
    localparam int          N_DIR          = 28;
    localparam int          N_RANDOM       = 500;
    localparam int          QUIET_TAIL     = 100;   // last requests without idling
    localparam int          LONG_HOLD      = 64;    // receiver back-pressure stretch
    localparam int          HOLD_AFTER     = 120;   // requests taken before that stretch
    localparam int          DRAIN_CYCLES   = 20;
    localparam int          CYCLE_LIMIT    = 200_000;
    localparam logic [5:0]  OP_FIRST_UNUSED = 6'd49;
    localparam logic [5:0]  OP_LAST_CODE    = 6'd63;

    // one decoded instruction, packed so that the last field lands lowest
    typedef struct packed {
        logic [63:0] ld;
        logic [63:0] link;
        logic [63:0] pc;
        logic [31:0] imm;
        logic [4:0]  rd;
        logic [4:0]  rs2;
        logic [4:0]  rs1;
        logic [5:0]  op;
    } t_ex_req;

    typedef struct packed {
        t_ex_req req;
        bit      known;     // expected result typed into the row
        t_result res;
    } t_dir_row;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // side channel that travels with each request, sampled on acceptance
    bit                     known_flag = 1'b0;
    t_result                known_res  = '0;

    logic [63:0]            arch_regs [32];
    t_result                pending_results [$];
    t_dir_row               dir_tab [N_DIR];
    int                     mismatch_cnt = 0;
    int                     accepted_cnt = 0;
    int                     cycle_cnt    = 0;
    bit                     quiet        = 1'b0;
    bit                     hold_done    = 1'b0;

    rv64i_execute_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),   // op, src1, src2, dest, imm, pc, link, load data
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata)    // redirect, target, written, value, mem, size, addr, store
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // execute model
    // ------------------------------------------------------------------------

    function automatic logic [63:0] word_sext(input logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // computes the result of one instruction and retires its writeback
    function automatic t_result execute_instr(input t_ex_req q);
        logic [63:0]        a, b, imm64, addr, val, tgt, sval;
        logic [5:0]         sh6b, sh6i;
        logic [4:0]         sh5b, sh5i;
        logic signed [31:0] lo_w;
        logic               wr, redir, taken;
        t_mem               mem;
        t_size              size;
        t_result            r;

        a     = (q.rs1 == 5'd0) ? 64'd0 : arch_regs[q.rs1];
        b     = (q.rs2 == 5'd0) ? 64'd0 : arch_regs[q.rs2];
        imm64 = {{32{q.imm[31]}}, q.imm};
        addr  = a + imm64;
        sh6b  = b[5:0];
        sh5b  = b[4:0];
        sh6i  = q.imm[5:0];
        sh5i  = q.imm[4:0];
        lo_w  = a[31:0];
        wr    = 1'b1;
        redir = 1'b0;
        taken = 1'b0;
        val   = '0;
        tgt   = '0;
        sval  = '0;
        mem   = MEM_NONE;
        size  = SZ_BYTE;

        case (q.op)
            OP_ADD:   val = a + b;
            OP_SUB:   val = a - b;
            OP_SLT:   val = {63'd0, $signed(a) < $signed(b)};
            OP_SLTU:  val = {63'd0, a < b};
            OP_XOR:   val = a ^ b;
            OP_SLL:   val = a << sh6b;
            OP_SRL:   val = a >> sh6b;
            OP_SRA:   val = $signed(a) >>> sh6b;
            OP_OR:    val = a | b;
            OP_AND:   val = a & b;
            OP_ADDW:  val = word_sext(a + b);
            OP_SLLW:  val = word_sext(a << sh5b);
            OP_SRLW:  val = word_sext({32'd0, a[31:0]} >> sh5b);
            OP_SUBW:  val = word_sext(a - b);
            OP_SRAW:  val = word_sext(lo_w >>> sh5b);
            OP_JALR: begin
                val   = q.link;
                redir = 1'b1;
                tgt   = addr & ~64'd1;
            end
            OP_LD: begin
                mem = MEM_LOAD; size = SZ_DOUBLE; val = q.ld;
            end
            OP_LB: begin
                mem = MEM_LOAD; size = SZ_BYTE; val = {{56{q.ld[7]}}, q.ld[7:0]};
            end
            OP_LBU: begin
                mem = MEM_LOAD; size = SZ_BYTE; val = {56'd0, q.ld[7:0]};
            end
            OP_LH: begin
                mem = MEM_LOAD; size = SZ_HALF; val = {{48{q.ld[15]}}, q.ld[15:0]};
            end
            OP_LHU: begin
                mem = MEM_LOAD; size = SZ_HALF; val = {48'd0, q.ld[15:0]};
            end
            OP_LW: begin
                mem = MEM_LOAD; size = SZ_WORD; val = word_sext(q.ld);
            end
            OP_LWU: begin
                mem = MEM_LOAD; size = SZ_WORD; val = {32'd0, q.ld[31:0]};
            end
            OP_ADDI:  val = a + imm64;
            OP_SLTI:  val = {63'd0, $signed(a) < $signed(imm64)};
            OP_SLTIU: val = {63'd0, a < imm64};
            OP_ANDI:  val = a & imm64;
            OP_ORI:   val = a | imm64;
            OP_XORI:  val = a ^ imm64;
            OP_SLLI:  val = a << sh6i;
            OP_SRLI:  val = a >> sh6i;
            OP_SRAI:  val = $signed(a) >>> sh6i;
            OP_ADDIW: val = word_sext(a + imm64);
            OP_SLLIW: val = word_sext(a << sh5i);
            OP_SRLIW: val = word_sext({32'd0, a[31:0]} >> sh5i);
            OP_SRAIW: val = word_sext(lo_w >>> sh5i);
            OP_SB: begin
                wr = 1'b0; mem = MEM_STORE; size = SZ_BYTE; sval = {56'd0, b[7:0]};
            end
            OP_SH: begin
                wr = 1'b0; mem = MEM_STORE; size = SZ_HALF; sval = {48'd0, b[15:0]};
            end
            OP_SW: begin
                wr = 1'b0; mem = MEM_STORE; size = SZ_WORD; sval = {32'd0, b[31:0]};
            end
            OP_SD: begin
                wr = 1'b0; mem = MEM_STORE; size = SZ_DOUBLE; sval = b;
            end
            OP_BEQ:  begin wr = 1'b0; taken = (a == b); end
            OP_BNE:  begin wr = 1'b0; taken = (a != b); end
            OP_BLT:  begin wr = 1'b0; taken = $signed(a) < $signed(b); end
            OP_BLTU: begin wr = 1'b0; taken = (a < b); end
            OP_BGE:  begin wr = 1'b0; taken = !($signed(a) < $signed(b)); end
            OP_BGEU: begin wr = 1'b0; taken = (a >= b); end
            OP_LUI:   val = imm64;
            OP_AUIPC: val = q.pc + imm64;
            OP_JAL: begin
                val   = q.link;
                redir = 1'b1;
                tgt   = q.pc + imm64;
            end
            default:  wr = 1'b0;    // unused codes do nothing
        endcase

        if (taken) begin
            redir = 1'b1;
            tgt   = q.pc + imm64;
        end
        // x0 swallows the writeback
        if (!wr || q.rd == 5'd0) begin
            wr  = 1'b0;
            val = '0;
        end else begin
            arch_regs[q.rd] = val;
        end

        r.redirect    = redir;
        r.target_pc   = redir ? tgt : 64'd0;
        r.reg_written = wr;
        r.write_value = val;
        r.mem_access  = mem;
        r.access_size = (mem != MEM_NONE) ? size : SZ_BYTE;
        r.access_addr = (mem != MEM_NONE) ? addr : 64'd0;
        r.store_value = sval;
        return r;
    endfunction

    function automatic t_result unpack_result(input logic [OUT_TDATA_W-1:0] d);
        t_result r;
        r.redirect    = d[0];
        r.target_pc   = d[64:1];
        r.reg_written = d[65];
        r.write_value = d[129:66];
        r.mem_access  = t_mem'(d[131:130]);
        r.access_size = t_size'(d[133:132]);
        r.access_addr = d[197:134];
        r.store_value = d[261:198];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_result outcome(input logic redir, input logic [63:0] tgt,
                                        input logic wr, input logic [63:0] val,
                                        input t_mem mem, input t_size size,
                                        input logic [63:0] addr, input logic [63:0] sval);
        t_result r;
        r.redirect    = redir;
        r.target_pc   = tgt;
        r.reg_written = wr;
        r.write_value = val;
        r.mem_access  = mem;
        r.access_size = size;
        r.access_addr = addr;
        r.store_value = sval;
        return r;
    endfunction

    function automatic t_dir_row row(input logic [5:0] op, input logic [4:0] rs1,
                                     input logic [4:0] rs2, input logic [4:0] rd,
                                     input logic [31:0] imm, input logic [63:0] pc,
                                     input logic [63:0] link, input logic [63:0] ld,
                                     input bit known, input t_result res);
        t_dir_row t;
        t.req   = '{ld: ld, link: link, pc: pc, imm: imm, rd: rd, rs2: rs2, rs1: rs1, op: op};
        t.known = known;
        t.res   = res;
        return t;
    endfunction

    // small register set most of the time so results feed later requests
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 7));
    endfunction

    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'd0;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($urandom_range(0, 63));
            6:       return -32'($urandom_range(1, 64));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] pick_wide();
        case ($urandom_range(0, 7))
            0:       return 64'd0;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // loads bring in full 64-bit values, so they are weighted up
    function automatic t_ex_req random_req();
        t_ex_req     q;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            q.op = 6'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
        else if (pick < 25)
            q.op = 6'($urandom_range(OP_LD, OP_LWU));
        else
            q.op = 6'($urandom_range(OP_ADD, OP_JAL));
        q.rs1 = pick_reg();
        q.rs2 = pick_reg();
        q.rd  = pick_reg();
        // equal operands so that equality branches go both ways
        if (q.op >= OP_BEQ && q.op <= OP_BGEU && $urandom_range(0, 2) == 0)
            q.rs2 = q.rs1;
        q.imm  = pick_imm();
        q.pc   = pick_wide();
        q.link = pick_wide();
        q.ld   = pick_wide();
        return q;
    endfunction

    // offers one request, with an optional gap in front, until it is taken
    task automatic drive_req(input t_ex_req q, input bit known, input t_result res);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_valid    <= 1'b1;
        s_tdata    <= {3'b000, q};
        known_flag <= known;
        known_res  <= res;
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            $display("%0t ns: %s expected %h actual %h", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // monitors
    // ------------------------------------------------------------------------

    // every accepted request is executed on the model at once, in order
    always @(posedge i_clk) begin : request_monitor
        t_result pred;
        if (i_rst_n && s_valid && s_ready) begin
            pred = execute_instr(t_ex_req'(s_tdata[244:0]));
            pending_results.push_back(known_flag ? known_res : pred);
            accepted_cnt++;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got, want;
        if (i_rst_n && m_valid && m_ready) begin
            got = unpack_result(m_tdata);
            if (pending_results.size() == 0) begin
                $display("%0t ns: result with nothing expected, actual %h", $time, m_tdata);
                mismatch_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("redirect",    64'(got.redirect),    64'(want.redirect));
                check_field("target_pc",   got.target_pc,        want.target_pc);
                check_field("reg_written", 64'(got.reg_written), 64'(want.reg_written));
                check_field("write_value", got.write_value,      want.write_value);
                check_field("mem_access",  64'(got.mem_access),  64'(want.mem_access));
                check_field("access_size", 64'(got.access_size), 64'(want.access_size));
                check_field("access_addr", got.access_addr,      want.access_addr);
                check_field("store_value", got.store_value,      want.store_value);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: random stalls, one long hold that backs the unit up
    // ------------------------------------------------------------------------

    initial begin : result_sink
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    initial begin : stimulus
        for (int r = 0; r < 32; r++)
            arch_regs[r] = '0;

        // registers start at zero, so the first rows have plain answers
        dir_tab = '{
            // all-zero operands right after reset
            row(OP_ADD,   5'd2, 5'd3, 5'd1,  32'd0, 64'd0, 64'd0, 64'd0, 1'b1,
                outcome(0, 0, 1, 64'd0, MEM_NONE, SZ_BYTE, 0, 0)),
            // upper immediate at the negative extreme
            row(OP_LUI,   5'd0, 5'd0, 5'd1,  32'h8000_0000, 64'd0, 64'd0, 64'd0, 1'b1,
                outcome(0, 0, 1, 64'hFFFF_FFFF_8000_0000, MEM_NONE, SZ_BYTE, 0, 0)),
            row(OP_ADDI,  5'd0, 5'd0, 5'd2,  32'h7FFF_FFFF, 64'd0, 64'd0, 64'd0, 1'b1,
                outcome(0, 0, 1, 64'h0000_0000_7FFF_FFFF, MEM_NONE, SZ_BYTE, 0, 0)),
            row(OP_ADDI,  5'd0, 5'd0, 5'd3,  32'hFFFF_FFFF, 64'd0, 64'd0, 64'd0, 1'b1,
                outcome(0, 0, 1, 64'hFFFF_FFFF_FFFF_FFFF, MEM_NONE, SZ_BYTE, 0, 0)),
            // negative offset from x0 wraps the address
            row(OP_LD,    5'd0, 5'd0, 5'd4,  32'hFFFF_FFF8, 64'd0, 64'd0,
                64'h8000_0000_0000_0001, 1'b1,
                outcome(0, 0, 1, 64'h8000_0000_0000_0001, MEM_LOAD, SZ_DOUBLE,
                        64'hFFFF_FFFF_FFFF_FFF8, 0)),
            row(OP_LB,    5'd0, 5'd0, 5'd5,  32'd0, 64'd0, 64'd0,
                64'h1234_5678_90AB_CD80, 1'b1,
                outcome(0, 0, 1, 64'hFFFF_FFFF_FFFF_FF80, MEM_LOAD, SZ_BYTE, 0, 0)),
            row(OP_LBU,   5'd3, 5'd0, 5'd6,  32'd1, 64'd0, 64'd0,
                64'h1234_5678_90AB_CD80, 1'b0, '0),
            row(OP_LH,    5'd2, 5'd0, 5'd7,  32'h8000_0000, 64'd0, 64'd0,
                64'hFFFF_FFFF_FFFF_8001, 1'b0, '0),
            row(OP_LHU,   5'd2, 5'd0, 5'd8,  32'h8000_0000, 64'd0, 64'd0,
                64'hFFFF_FFFF_FFFF_8001, 1'b0, '0),
            row(OP_LW,    5'd1, 5'd0, 5'd9,  32'h7FFF_FFFF, 64'd0, 64'd0,
                64'h0000_0000_8000_0000, 1'b0, '0),
            row(OP_LWU,   5'd1, 5'd0, 5'd10, 32'h7FFF_FFFF, 64'd0, 64'd0,
                64'hFFFF_FFFF_7FFF_FFFF, 1'b0, '0),
            row(OP_SUB,   5'd0, 5'd1, 5'd11, 32'd0, 64'd0, 64'd0, 64'd0, 1'b0, '0),
            row(OP_SLT,   5'd1, 5'd2, 5'd12, 32'd0, 64'd0, 64'd0, 64'd0, 1'b0, '0),
            row(OP_SLTU,  5'd1, 5'd2, 5'd13, 32'd0, 64'd0, 64'd0, 64'd0, 1'b0, '0),
            // shift amount 63 from the register
            row(OP_SRA,   5'd4, 5'd3, 5'd14, 32'd0, 64'd0, 64'd0, 64'd0, 1'b0, '0),
            // word arithmetic shift of a negative low word by 31
            row(OP_SRAW,  5'd1, 5'd2, 5'd15, 32'd0, 64'd0, 64'd0, 64'd0, 1'b0, '0),
            // upper immediate bits of a shift are ignored
            row(OP_SRAIW, 5'd4, 5'd0, 5'd16, 32'hFFFF_FFE1, 64'd0, 64'd0, 64'd0, 1'b0, '0),
            row(OP_SLLI,  5'd3, 5'd0, 5'd17, 32'h0000_003F, 64'd0, 64'd0, 64'd0, 1'b0, '0),
            // unused operation code
            row(OP_LAST_CODE, 5'd3, 5'd3, 5'd5, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                outcome(0, 0, 0, 64'd0, MEM_NONE, SZ_BYTE, 0, 0)),
            // destination x0 drops the write
            row(OP_ADDI,  5'd3, 5'd0, 5'd0,  32'd5, 64'd0, 64'd0, 64'd0, 1'b1,
                outcome(0, 0, 0, 64'd0, MEM_NONE, SZ_BYTE, 0, 0)),
            // store address wraps to zero
            row(OP_SD,    5'd3, 5'd3, 5'd9,  32'd1, 64'd0, 64'd0, 64'd0, 1'b1,
                outcome(0, 0, 0, 64'd0, MEM_STORE, SZ_DOUBLE, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF)),
            row(OP_SB,    5'd0, 5'd4, 5'd9,  32'hFFFF_FFFF, 64'd0, 64'd0, 64'd0, 1'b0, '0),
            // taken branch backwards from pc zero
            row(OP_BEQ,   5'd0, 5'd0, 5'd9,  32'hFFFF_FFFC, 64'd0, 64'd0, 64'd0, 1'b1,
                outcome(1, 64'hFFFF_FFFF_FFFF_FFFC, 0, 64'd0, MEM_NONE, SZ_BYTE, 0, 0)),
            row(OP_BLT,   5'd1, 5'd2, 5'd9,  32'h0000_0100, 64'h8000_0000_0000_0000,
                64'd0, 64'd0, 1'b0, '0),
            row(OP_BGEU,  5'd1, 5'd2, 5'd9,  32'h7FFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFF,
                64'd0, 64'd0, 1'b0, '0),
            row(OP_JAL,   5'd3, 5'd0, 5'd1,  32'h7FFF_FFFE, 64'hFFFF_FFFF_FFFF_FFF0,
                64'h0000_0000_0000_1234, 64'd0, 1'b0, '0),
            // link register is also the base: base is read first
            row(OP_JALR,  5'd1, 5'd0, 5'd1,  32'd1, 64'd0, 64'h0123_4567_89AB_CDEF,
                64'd0, 1'b0, '0),
            row(OP_AUIPC, 5'd0, 5'd0, 5'd20, 32'h8000_0000, 64'h0000_0000_0000_1000,
                64'd0, 64'd0, 1'b0, '0)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++)
            drive_req(dir_tab[i].req, dir_tab[i].known, dir_tab[i].res);

        for (int i = 0; i < N_RANDOM; i++) begin
            quiet = (i >= N_RANDOM - QUIET_TAIL);
            drive_req(random_req(), 1'b0, '0);
        end
        s_valid <= 1'b0;

        // wait out the last results, then a drain period for stray ones
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
design/rv64ex_pkg.sv
design/rv64ex_regfile.sv
design/rv64ex_alu.sv
design/rv64i_execute_unit.sv
design/rv64ex_checker.sv
verif/tb.sv
